@@ design/crr_pkg.sv @@
package crr_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OPEN_REF  = 2'd0;
    localparam logic [1:0] CFG_CLOSE_REF = 2'd1;
    localparam logic [1:0] CFG_MAX_STEP  = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Q16 one, lower bound of the speed ratio and default step size.
    localparam logic [16:0] Q16_ONE      = 17'd65536;
    localparam logic [16:0] SPEED_MIN    = 17'd655;
    localparam logic [15:0] STEP_DEFAULT = 16'd300;

    // Reset values of the configuration registers.
    localparam logic signed [15:0] OPEN_RESET  = 16'sd0;
    localparam logic signed [15:0] CLOSE_RESET = 16'sd19000;
    localparam logic [15:0]        STEP_RESET  = 16'd300;

    // Input item: a closure command or a timer tick.
    typedef struct packed {
        logic        kind;
        logic [16:0] closure;
        logic [16:0] speed_frac;
        logic [15:0] duration_ticks;
    } in_t;

    // Result item: one reference per active tick.
    typedef struct packed {
        logic signed [15:0] reference;
        logic               done_res;
    } out_t;

endpackage

@@ design/closure_reference_ramp.sv @@
// Closure reference ramp generator. A command transfer (kind 0) sets the target
// open + round((close - open) * closure / 65536) and restarts the ramp from the
// last reference sent, or from the open reference if none has been sent; it gives
// no result. Each tick transfer (kind 1) during an active ramp gives one reference,
// and the last one of the ramp carries done_res; a tick with no active ramp gives
// nothing. With duration_ticks zero the reference moves by a fixed step per tick,
// otherwise it is interpolated linearly over duration_ticks ticks. All arithmetic
// runs on one shared 17x18 bit multiplier and a bit-serial divider under a small
// sequencer, and s_ready is low while an item is in work. A command passes through
// ST_MUL and ST_FIN, a speed mode tick through ST_MUL, ST_FIN and ST_EMIT, and an
// interpolating tick through ST_MUL, ST_FIN, ST_DIV, ST_RND and ST_EMIT; the
// divider gives one quotient bit per cycle. A finished result sits in the output
// register until it is taken while the next item is accepted; a result that finds
// the register full holds the block in ST_EMIT until the waiting one is taken.
module closure_reference_ramp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  crr_pkg::in_t                           s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output crr_pkg::out_t                          m_data,
    input  logic                                   cfg_we,
    input  logic [crr_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [crr_pkg::CFG_DATA_W-1:0]         cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN,
        ST_DIV,
        ST_RND,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_CMD,
        OP_SPD,
        OP_DUR
    } op_t;

    // Saturate a 19 bit signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Registers and their next values.
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic signed [15:0] open_reg, open_next;
    logic signed [15:0] close_reg, close_next;
    logic [15:0]        max_step_reg, max_step_next;
    logic               active_reg, active_next;
    logic               speed_mode_reg, speed_mode_next;
    logic signed [15:0] start_reg, start_next;
    logic signed [15:0] present_reg, present_next;
    logic signed [15:0] goal_reg, goal_next;
    logic [16:0]        held_speed_reg, held_speed_next;
    logic [15:0]        ramp_len_reg, ramp_len_next;
    logic [15:0]        elapsed_reg, elapsed_next;
    logic signed [15:0] last_ref_reg, last_ref_next;
    logic               last_valid_reg, last_valid_next;
    logic signed [16:0] mul_a_reg, mul_a_next;
    logic [16:0]        mul_b_reg, mul_b_next;
    logic signed [34:0] prod_reg, prod_next;
    logic [31:0]        quo_reg, quo_next;
    logic [15:0]        rem_reg, rem_next;
    logic [4:0]         div_cnt_reg, div_cnt_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] res_ref_reg, res_ref_next;
    logic               res_done_reg, res_done_next;
    logic               m_valid_reg, m_valid_next;
    crr_pkg::out_t      m_data_reg, m_data_next;

    // Shared multiplier.
    logic signed [34:0] mul_res;
    assign mul_res = mul_a_reg * $signed({1'b0, mul_b_reg});

    // Operands prepared at acceptance of an item.
    logic [16:0]        closure_c;
    logic [16:0]        speed_c;
    logic signed [16:0] span;
    logic signed [16:0] ramp_diff;
    logic [15:0]        elapsed_inc;
    logic [15:0]        step_size_cfg;

    assign closure_c = (s_data.closure > crr_pkg::Q16_ONE) ? crr_pkg::Q16_ONE
                                                           : s_data.closure;
    assign speed_c   = (s_data.speed_frac > crr_pkg::Q16_ONE) ? crr_pkg::Q16_ONE :
                       (s_data.speed_frac < crr_pkg::SPEED_MIN) ? crr_pkg::SPEED_MIN :
                       s_data.speed_frac;
    assign span      = {close_reg[15], close_reg} - {open_reg[15], open_reg};
    assign ramp_diff = {goal_reg[15], goal_reg} - {start_reg[15], start_reg};
    assign elapsed_inc = (elapsed_reg < ramp_len_reg) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign step_size_cfg = (max_step_reg == 16'd0) ? crr_pkg::STEP_DEFAULT : max_step_reg;

    // Product magnitude and the target rounded half away from zero.
    logic [34:0]        prod_mag;
    logic [34:0]        prod_rnd;
    logic signed [17:0] target_q;
    logic signed [18:0] target_sum;

    assign prod_mag   = prod_reg[34] ? 35'(-prod_reg) : 35'(prod_reg);
    assign prod_rnd   = prod_mag + 35'd32768;
    assign target_q   = prod_reg[34] ? -$signed({1'b0, prod_rnd[32:16]})
                                     : $signed({1'b0, prod_rnd[32:16]});
    assign target_sum = {{3{open_reg[15]}}, open_reg} + {target_q[17], target_q};

    // Speed mode step and distance to the target.
    logic [16:0]        step_raw;
    logic [16:0]        step_size;
    logic signed [16:0] delta;
    logic [16:0]        delta_mag;
    logic signed [18:0] step_sum;

    assign step_raw  = prod_rnd[32:16];
    assign step_size = (step_raw == 17'd0) ? 17'd1 : step_raw;
    assign delta     = {goal_reg[15], goal_reg} - {present_reg[15], present_reg};
    assign delta_mag = delta[16] ? 17'(-delta) : 17'(delta);
    assign step_sum  = delta[16] ? {{3{present_reg[15]}}, present_reg} - {2'b00, step_size}
                                 : {{3{present_reg[15]}}, present_reg} + {2'b00, step_size};

    // One restoring division step per cycle.
    logic [16:0] div_trial;
    logic        div_ge;
    assign div_trial = {rem_reg, quo_reg[31]};
    assign div_ge    = div_trial >= {1'b0, ramp_len_reg};

    // Interpolated reference from quotient and remainder.
    logic               round_up;
    logic [16:0]        quo_rnd;
    logic signed [17:0] interp_q;
    logic signed [18:0] interp_sum;

    assign round_up   = {rem_reg, 1'b0} >= {1'b0, ramp_len_reg};
    assign quo_rnd    = {1'b0, quo_reg[15:0]} + {16'd0, round_up};
    assign interp_q   = neg_reg ? -$signed({1'b0, quo_rnd}) : $signed({1'b0, quo_rnd});
    assign interp_sum = {{3{start_reg[15]}}, start_reg} + {interp_q[17], interp_q};

    // Sequencer and state update.
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        open_next       = open_reg;
        close_next      = close_reg;
        max_step_next   = max_step_reg;
        active_next     = active_reg;
        speed_mode_next = speed_mode_reg;
        start_next      = start_reg;
        present_next    = present_reg;
        goal_next       = goal_reg;
        held_speed_next = held_speed_reg;
        ramp_len_next   = ramp_len_reg;
        elapsed_next    = elapsed_reg;
        last_ref_next   = last_ref_reg;
        last_valid_next = last_valid_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        prod_next       = prod_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        neg_next        = neg_reg;
        res_ref_next    = res_ref_reg;
        res_done_next   = res_done_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        // The output register empties on a result transfer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes; indexes past the list are ignored.
        if (cfg_we) begin
            unique case (cfg_index)
                crr_pkg::CFG_OPEN_REF:  open_next     = $signed(cfg_data);
                crr_pkg::CFG_CLOSE_REF: close_next    = $signed(cfg_data);
                crr_pkg::CFG_MAX_STEP:  max_step_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_data.kind) begin
                        // Command: restart the ramp from the last reference sent.
                        op_next         = OP_CMD;
                        mul_a_next      = span;
                        mul_b_next      = closure_c;
                        start_next      = last_valid_reg ? last_ref_reg : open_reg;
                        present_next    = last_valid_reg ? last_ref_reg : open_reg;
                        held_speed_next = speed_c;
                        ramp_len_next   = s_data.duration_ticks;
                        elapsed_next    = 16'd0;
                        speed_mode_next = (s_data.duration_ticks == 16'd0);
                        active_next     = 1'b1;
                        state_next      = ST_MUL;
                    end else if (active_reg) begin
                        if (speed_mode_reg) begin
                            op_next    = OP_SPD;
                            mul_a_next = $signed({1'b0, step_size_cfg});
                            mul_b_next = held_speed_reg;
                            state_next = ST_MUL;
                        end else if (ramp_len_reg == 16'd0) begin
                            active_next   = 1'b0;
                            present_next  = goal_reg;
                            last_ref_next = goal_reg;
                            last_valid_next = 1'b1;
                            res_ref_next  = goal_reg;
                            res_done_next = 1'b1;
                            state_next    = ST_EMIT;
                        end else begin
                            op_next      = OP_DUR;
                            elapsed_next = elapsed_inc;
                            mul_a_next   = ramp_diff;
                            mul_b_next   = {1'b0, elapsed_inc};
                            state_next   = ST_MUL;
                        end
                    end
                end
            end

            ST_MUL: begin
                prod_next  = mul_res;
                state_next = ST_FIN;
            end

            ST_FIN: begin
                unique case (op_reg)
                    OP_CMD: begin
                        goal_next  = sat16(target_sum);
                        state_next = ST_IDLE;
                    end
                    OP_SPD: begin
                        if (delta_mag <= step_size) begin
                            present_next  = goal_reg;
                            active_next   = 1'b0;
                            res_ref_next  = goal_reg;
                            res_done_next = 1'b1;
                            last_ref_next = goal_reg;
                        end else begin
                            present_next  = sat16(step_sum);
                            res_ref_next  = sat16(step_sum);
                            res_done_next = 1'b0;
                            last_ref_next = sat16(step_sum);
                        end
                        last_valid_next = 1'b1;
                        state_next      = ST_EMIT;
                    end
                    OP_DUR: begin
                        // Divide the product magnitude by the ramp length.
                        quo_next     = prod_mag[31:0];
                        rem_next     = 16'd0;
                        neg_next     = prod_reg[34];
                        div_cnt_next = 5'd0;
                        state_next   = ST_DIV;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end

            ST_DIV: begin
                rem_next     = div_ge ? 16'(div_trial - {1'b0, ramp_len_reg})
                                      : div_trial[15:0];
                quo_next     = {quo_reg[30:0], div_ge};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31) begin
                    state_next = ST_RND;
                end
            end

            ST_RND: begin
                present_next    = sat16(interp_sum);
                res_ref_next    = sat16(interp_sum);
                last_ref_next   = sat16(interp_sum);
                last_valid_next = 1'b1;
                res_done_next   = (elapsed_reg >= ramp_len_reg);
                if (elapsed_reg >= ramp_len_reg) begin
                    active_next = 1'b0;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                // Wait for room in the output register.
                if (!m_valid_reg || m_ready) begin
                    m_data_next.reference = res_ref_reg;
                    m_data_next.done_res  = res_done_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_CMD;
            open_reg       <= crr_pkg::OPEN_RESET;
            close_reg      <= crr_pkg::CLOSE_RESET;
            max_step_reg   <= crr_pkg::STEP_RESET;
            active_reg     <= 1'b0;
            speed_mode_reg <= 1'b0;
            start_reg      <= 16'sd0;
            present_reg    <= 16'sd0;
            goal_reg       <= 16'sd0;
            held_speed_reg <= crr_pkg::Q16_ONE;
            ramp_len_reg   <= 16'd0;
            elapsed_reg    <= 16'd0;
            last_ref_reg   <= 16'sd0;
            last_valid_reg <= 1'b0;
            div_cnt_reg    <= 5'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            open_reg       <= open_next;
            close_reg      <= close_next;
            max_step_reg   <= max_step_next;
            active_reg     <= active_next;
            speed_mode_reg <= speed_mode_next;
            start_reg      <= start_next;
            present_reg    <= present_next;
            goal_reg       <= goal_next;
            held_speed_reg <= held_speed_next;
            ramp_len_reg   <= ramp_len_next;
            elapsed_reg    <= elapsed_next;
            last_ref_reg   <= last_ref_next;
            last_valid_reg <= last_valid_next;
            div_cnt_reg    <= div_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        res_ref_reg  <= res_ref_next;
        res_done_reg <= res_done_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
